// ===== rtl/qls_pkg.sv =====
// shared constants, types and helpers of the q-learning step engine
package qls_pkg;

  localparam int STATE_COUNT = 256;
  localparam int MAX_ACTIONS = 8;
  localparam int STATE_W     = $clog2(STATE_COUNT);
  localparam int SLOT_W      = $clog2(MAX_ACTIONS);
  localparam int CNT_W       = $clog2(MAX_ACTIONS + 1);
  localparam int ADDR_W      = STATE_W + SLOT_W;
  localparam int Q_DEPTH     = STATE_COUNT * MAX_ACTIONS;
  localparam int Q_W         = 32;
  localparam int FRAC_W      = 17;
  localparam int DRAW_W      = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [FRAC_W-1:0] ONE_FRAC       = 17'd65536;
  localparam logic [FRAC_W-1:0] LEARN_RATE_RST = 17'd26214;
  localparam logic [FRAC_W-1:0] DISCOUNT_RST   = 17'd39322;

  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPLORE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLIP       = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load_wr;
    logic clr_step;
    logic cnt_rd;
    logic cnt_take;
    logic succ_sel;
    logic mod_start;
    logic mod_step;
    logic scan_start;
    logic scan_step;
    logic choose;
    logic tbl_rd;
    logic tbl_take;
    logic mul1;
    logic err_calc;
    logic mul2;
    logic fin;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic scan_done;
    logic out_busy;
  } sts_t;

  function automatic logic [FRAC_W-1:0] frac_clamp(input logic [FRAC_W-1:0] v);
    frac_clamp = (v > ONE_FRAC) ? ONE_FRAC : v;
  endfunction

endpackage

// ===== rtl/qls_ram.sv =====
// generic single-write, single-read ram with registered read data
module qls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/qls_ctrl.sv =====
// sequencing state machine of the q-learning step engine
module qls_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          op,
  input  qls_pkg::sts_t sts,
  output qls_pkg::cmd_t cmd,
  output logic          idle
);
  import qls_pkg::*;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_LOAD   = 5'd2;
  localparam logic [4:0] S_CNT_S  = 5'd3;
  localparam logic [4:0] S_CNTW_S = 5'd4;
  localparam logic [4:0] S_MOD    = 5'd5;
  localparam logic [4:0] S_SCAN_S = 5'd6;
  localparam logic [4:0] S_CHOOSE = 5'd7;
  localparam logic [4:0] S_RD     = 5'd8;
  localparam logic [4:0] S_RDW    = 5'd9;
  localparam logic [4:0] S_CNT_N  = 5'd10;
  localparam logic [4:0] S_CNTW_N = 5'd11;
  localparam logic [4:0] S_SCAN_N = 5'd12;
  localparam logic [4:0] S_MUL1   = 5'd13;
  localparam logic [4:0] S_ERR    = 5'd14;
  localparam logic [4:0] S_MUL2   = 5'd15;
  localparam logic [4:0] S_FIN    = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.capture = accept;
        if (accept) state_nxt = op ? S_CNT_S : S_LOAD;
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_CNT_S: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = S_CNTW_S;
      end
      S_CNTW_S: begin
        cmd.cnt_take   = 1'b1;
        cmd.mod_start  = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) state_nxt = S_SCAN_S;
      end
      S_SCAN_S: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_CHOOSE;
      end
      S_CHOOSE: begin
        cmd.choose = 1'b1;
        state_nxt  = S_RD;
      end
      S_RD: begin
        cmd.tbl_rd = 1'b1;
        state_nxt  = S_RDW;
      end
      S_RDW: begin
        cmd.tbl_take = 1'b1;
        state_nxt    = S_CNT_N;
      end
      S_CNT_N: begin
        cmd.cnt_rd   = 1'b1;
        cmd.succ_sel = 1'b1;
        state_nxt    = S_CNTW_N;
      end
      S_CNTW_N: begin
        cmd.cnt_take   = 1'b1;
        cmd.succ_sel   = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN_N;
      end
      S_SCAN_N: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.err_calc = 1'b1;
        state_nxt    = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

endmodule

// ===== rtl/qls_dp.sv =====
// datapath: tables, config registers, modulo unit, max scan and q update
module qls_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  qls_pkg::cmd_t                        cmd,
  output qls_pkg::sts_t                        sts,
  input  logic                                 cfg_we,
  input  logic [qls_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [qls_pkg::FRAC_W-1:0]           cfg_data,
  input  logic [7:0]                           in_state_id,
  input  logic [2:0]                           in_slot,
  input  logic [7:0]                           in_successor,
  input  logic signed [31:0]                   in_slot_reward,
  input  logic [3:0]                           in_action_count,
  input  logic [15:0]                          in_explore_draw,
  input  logic [15:0]                          in_explore_pick,
  input  logic [15:0]                          in_slip_draw,
  input  logic [15:0]                          in_slip_pick,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [2:0]                           out_chosen_slot,
  output logic [2:0]                           out_taken_slot,
  output logic [7:0]                           out_reached_state,
  output logic signed [31:0]                   out_step_reward,
  output logic signed [31:0]                   out_new_q
);
  import qls_pkg::*;

  // config
  logic [FRAC_W-1:0] lr_r, disc_r, expl_r, slip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= LEARN_RATE_RST;
      disc_r <= DISCOUNT_RST;
      expl_r <= '0;
      slip_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARN_RATE: lr_r   <= frac_clamp(cfg_data);
        REG_DISCOUNT:   disc_r <= frac_clamp(cfg_data);
        REG_EXPLORE:    expl_r <= frac_clamp(cfg_data);
        REG_SLIP:       slip_r <= frac_clamp(cfg_data);
        default: ;
      endcase
    end
  end

  // captured item
  logic [STATE_W-1:0]  st_r, succ_in_r;
  logic [2:0]          slot_r;
  logic signed [31:0]  rew_in_r;
  logic [3:0]          cnt_in_r;
  logic [DRAW_W-1:0]   edraw_r, epick_r, sdraw_r, spick_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      st_r      <= in_state_id[STATE_W-1:0];
      slot_r    <= in_slot;
      succ_in_r <= in_successor[STATE_W-1:0];
      rew_in_r  <= in_slot_reward;
      cnt_in_r  <= in_action_count;
      edraw_r   <= in_explore_draw;
      epick_r   <= in_explore_pick;
      sdraw_r   <= in_slip_draw;
      spick_r   <= in_slip_pick;
    end
  end

  // working registers
  logic [CNT_W-1:0]    n_r;
  logic [CNT_W-1:0]    rem_e_r, rem_s_r;
  logic [3:0]          bit_r;
  logic [CNT_W-1:0]    scan_idx_r;
  logic                scan_pend_r;
  logic [SLOT_W-1:0]   scan_pidx_r;
  logic [STATE_W-1:0]  scan_st_r;
  logic signed [31:0]  best_q_r;
  logic [SLOT_W-1:0]   best_idx_r;
  logic [SLOT_W-1:0]   chosen_r, taken_r;
  logic [STATE_W-1:0]  next_r;
  logic signed [31:0]  rew_r, qold_r;
  logic signed [49:0]  p1_r;
  logic signed [34:0]  err_r;
  logic signed [52:0]  p2_r;
  logic signed [31:0]  nq_r;
  logic [ADDR_W-1:0]   clr_cnt_r;

  // ram ports
  logic                q_we;
  logic [ADDR_W-1:0]   q_waddr, q_raddr;
  logic [31:0]         q_wdata, q_rdata;
  logic                tbl_we;
  logic [ADDR_W-1:0]   load_addr, take_addr;
  logic [7:0]          succ_rdata;
  logic [31:0]         rew_rdata;
  logic [STATE_W-1:0]  cnt_raddr;
  logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
  logic                slot_ok;

  assign slot_ok   = (32'(slot_r) < MAX_ACTIONS);
  assign load_addr = {st_r, SLOT_W'(slot_r)};
  assign take_addr = {st_r, taken_r};
  assign tbl_we    = cmd.load_wr && slot_ok;

  always_comb begin
    if (cnt_in_r == 4'd0) begin
      cnt_wdata = CNT_W'(1);
    end else if (32'(cnt_in_r) > MAX_ACTIONS) begin
      cnt_wdata = CNT_W'(MAX_ACTIONS);
    end else begin
      cnt_wdata = CNT_W'(cnt_in_r);
    end
  end

  always_comb begin
    q_we    = cmd.clr_step || tbl_we || cmd.out_load;
    q_wdata = cmd.out_load ? nq_r : 32'd0;
    if (cmd.clr_step) begin
      q_waddr = clr_cnt_r;
    end else if (cmd.load_wr) begin
      q_waddr = load_addr;
    end else begin
      q_waddr = {st_r, chosen_r};
    end
    q_raddr = cmd.tbl_rd ? {st_r, chosen_r} : {scan_st_r, scan_idx_r[SLOT_W-1:0]};
  end

  assign cnt_raddr = cmd.succ_sel ? next_r : st_r;

  qls_ram #(.WIDTH(32), .DEPTH(Q_DEPTH)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  qls_ram #(.WIDTH(8), .DEPTH(Q_DEPTH)) u_succ_ram (
    .clk(clk), .we(tbl_we), .waddr(load_addr), .wdata(8'(succ_in_r)),
    .raddr(take_addr), .rdata(succ_rdata)
  );

  qls_ram #(.WIDTH(32), .DEPTH(Q_DEPTH)) u_rew_ram (
    .clk(clk), .we(tbl_we), .waddr(load_addr), .wdata(rew_in_r),
    .raddr(take_addr), .rdata(rew_rdata)
  );

  qls_ram #(.WIDTH(CNT_W), .DEPTH(STATE_COUNT)) u_cnt_ram (
    .clk(clk), .we(cmd.load_wr), .waddr(st_r), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  // clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  assign sts.clr_done = (clr_cnt_r == ADDR_W'(Q_DEPTH - 1));

  // restoring remainder, one pick bit per cycle for both picks
  logic [CNT_W:0] re_t, rs_t;

  assign re_t = {rem_e_r, epick_r[bit_r]};
  assign rs_t = {rem_s_r, spick_r[bit_r]};

  always_ff @(posedge clk) begin
    if (cmd.cnt_take) begin
      if (cnt_rdata == '0) begin
        n_r <= CNT_W'(1);
      end else if (32'(cnt_rdata) > MAX_ACTIONS) begin
        n_r <= CNT_W'(MAX_ACTIONS);
      end else begin
        n_r <= cnt_rdata;
      end
    end
    if (cmd.mod_start) begin
      rem_e_r <= '0;
      rem_s_r <= '0;
      bit_r   <= 4'(DRAW_W - 1);
    end else if (cmd.mod_step) begin
      rem_e_r <= (re_t >= {1'b0, n_r}) ? CNT_W'(re_t - {1'b0, n_r}) : CNT_W'(re_t);
      rem_s_r <= (rs_t >= {1'b0, n_r}) ? CNT_W'(rs_t - {1'b0, n_r}) : CNT_W'(rs_t);
      bit_r   <= bit_r - 4'd1;
    end
  end

  assign sts.mod_done = (bit_r == 4'd0);

  // first-max scan over the slots of one state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pend_r <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_pend_r <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_pend_r <= (scan_idx_r < n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
      scan_st_r  <= cmd.succ_sel ? next_r : st_r;
    end else if (cmd.scan_step) begin
      if (scan_idx_r < n_r) begin
        scan_idx_r  <= scan_idx_r + CNT_W'(1);
        scan_pidx_r <= scan_idx_r[SLOT_W-1:0];
      end
      if (scan_pend_r) begin
        if (scan_pidx_r == '0 || $signed(q_rdata) > best_q_r) begin
          best_q_r   <= $signed(q_rdata);
          best_idx_r <= scan_pidx_r;
        end
      end
    end
  end

  assign sts.scan_done = (scan_idx_r >= n_r) && !scan_pend_r;

  // action choice and table lookups
  logic              explore, slip;
  logic [SLOT_W-1:0] chosen_nxt;

  assign explore    = ({1'b0, edraw_r} <= expl_r);
  assign slip       = ({1'b0, sdraw_r} <= slip_r);
  assign chosen_nxt = explore ? rem_e_r[SLOT_W-1:0] : best_idx_r;

  always_ff @(posedge clk) begin
    if (cmd.choose) begin
      chosen_r <= chosen_nxt;
      taken_r  <= slip ? rem_s_r[SLOT_W-1:0] : chosen_nxt;
    end
    if (cmd.tbl_take) begin
      next_r <= succ_rdata[STATE_W-1:0];
      rew_r  <= $signed(rew_rdata);
      qold_r <= $signed(q_rdata);
    end
  end

  // update arithmetic, rounding ties toward plus infinity
  logic signed [49:0] p1_rnd;
  logic signed [52:0] p2_rnd;
  logic signed [37:0] nq_wide;

  assign p1_rnd  = p1_r + 50'sd32768;
  assign p2_rnd  = p2_r + 53'sd32768;
  assign nq_wide = 38'(qold_r) + 38'(p2_rnd >>> 16);

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p1_r <= $signed({1'b0, disc_r}) * best_q_r;
    end
    if (cmd.err_calc) begin
      err_r <= 35'(rew_r) + 35'(p1_rnd >>> 16) - 35'(qold_r);
    end
    if (cmd.mul2) begin
      p2_r <= $signed({1'b0, lr_r}) * err_r;
    end
    if (cmd.fin) begin
      if (nq_wide > 38'sd2147483647) begin
        nq_r <= 32'sh7fffffff;
      end else if (nq_wide < -38'sd2147483648) begin
        nq_r <= 32'sh80000000;
      end else begin
        nq_r <= 32'(nq_wide);
      end
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_chosen_slot   <= 3'(chosen_r);
      out_taken_slot    <= 3'(taken_r);
      out_reached_state <= 8'(next_r);
      out_step_reward   <= rew_r;
      out_new_q         <= nq_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

// ===== rtl/tabular_q_learning_step_top.sv =====
// top level of the tabular q-learning step engine
// sequence: a step reads the action count, runs the bit-serial remainder unit over its picks
//   and two slot scans of n and m slots (n, m = action counts of the state and of its successor)
//   through the single read port of the q ram; a load beat holds the engine while it is written
// flow: one beat at a time, a new beat is taken only once the last is through; a result stalled in the
//   output register holds the engine
// reset: synchronous rst_n; afterwards a clearing pass zeroes every entry of the
//   q ram, input stalled meanwhile; config writes are taken at any time
module tabular_q_learning_step_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // config port
  input  logic                          cfg_we,
  input  logic [qls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qls_pkg::FRAC_W-1:0]    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [7:0]                    in_state_id,
  input  logic [2:0]                    in_slot,
  input  logic [7:0]                    in_successor,
  input  logic signed [31:0]            in_slot_reward,
  input  logic [3:0]                    in_action_count,
  input  logic [15:0]                   in_explore_draw,
  input  logic [15:0]                   in_explore_pick,
  input  logic [15:0]                   in_slip_draw,
  input  logic [15:0]                   in_slip_pick,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_chosen_slot,
  output logic [2:0]                    out_taken_slot,
  output logic [7:0]                    out_reached_state,
  output logic signed [31:0]            out_step_reward,
  output logic signed [31:0]            out_new_q
);
  import qls_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle;
  logic accept;

  // a beat enters only while the sequencer sits idle
  assign in_stall = !idle;
  assign accept   = in_valid && idle;

  qls_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .op     (in_op),
    .sts    (sts),
    .cmd    (cmd),
    .idle   (idle)
  );

  // tables, config, remainder unit, scan and update math
  qls_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_state_id       (in_state_id),
    .in_slot           (in_slot),
    .in_successor      (in_successor),
    .in_slot_reward    (in_slot_reward),
    .in_action_count   (in_action_count),
    .in_explore_draw   (in_explore_draw),
    .in_explore_pick   (in_explore_pick),
    .in_slip_draw      (in_slip_draw),
    .in_slip_pick      (in_slip_pick),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_chosen_slot   (out_chosen_slot),
    .out_taken_slot    (out_taken_slot),
    .out_reached_state (out_reached_state),
    .out_step_reward   (out_step_reward),
    .out_new_q         (out_new_q)
  );

endmodule
